### rtl/dshsp_pkg.sv
// ----------------------------------------------------------------------------
// Dual stepper half-step positioner package
// Shared widths, register indexes, alarm codes and the channel result type.
// ----------------------------------------------------------------------------
`default_nettype none

package dshsp_pkg;

	// Width of each channel's position counter.
	localparam int POSITION_BITS = 16;
	// Width of the target field and of the position field on the stream.
	localparam int TARGET_BITS   = 16;
	// Compare width: both operands are sign-extended to the wider of the two.
	localparam int CMP_BITS      = (POSITION_BITS > TARGET_BITS) ? POSITION_BITS : TARGET_BITS;

	localparam int PHASE_BITS    = 3;
	localparam int COIL_BITS     = 4;
	localparam int ALARM_BITS    = 3;

	localparam logic [PHASE_BITS-1:0] PHASE_LAST = 3'd7;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_UD_TABLE = 2'd0;
	localparam logic [1:0] REG_OC_TABLE = 2'd1;
	localparam logic [1:0] REG_UD_OFF   = 2'd2;
	localparam logic [1:0] REG_OC_OFF   = 2'd3;

	localparam logic [31:0]          TABLE_RESET = 32'h98C4_6231;
	localparam logic [COIL_BITS-1:0] OFF_RESET   = 4'h0;

	// Alarm codes rewritten while both motors are stopped.
	localparam logic [ALARM_BITS-1:0] ALARM_WARN_IN   = 3'd4;
	localparam logic [ALARM_BITS-1:0] ALARM_WARN_OUT  = 3'd2;
	localparam logic [ALARM_BITS-1:0] ALARM_CLEAR_IN  = 3'd5;
	localparam logic [ALARM_BITS-1:0] ALARM_CLEAR_OUT = 3'd0;

	// What one channel reports for the tick being accepted.
	typedef struct packed {
		logic [COIL_BITS-1:0]   drive;
		logic [TARGET_BITS-1:0] position;
		logic                   running;
	} chan_res_t;

endpackage

`default_nettype wire

### rtl/dshsp_channel.sv
// ----------------------------------------------------------------------------
// Dual stepper half-step positioner: one channel
// Phase, position counter, run flag and held coil pattern of one motor.
// ----------------------------------------------------------------------------
`default_nettype none

module dshsp_channel
	import dshsp_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire logic                   start,
	input  wire logic [TARGET_BITS-1:0] target,
	input  wire logic [31:0]            phase_table,
	input  wire logic [COIL_BITS-1:0]   off_pattern,
	output chan_res_t                   res
);

	logic [PHASE_BITS-1:0]    phase_q, phase_n;
	logic [POSITION_BITS-1:0] count_q, count_n;
	logic                     run_q, run_n;
	logic [COIL_BITS-1:0]     drive_q, drive_n;

	logic signed [CMP_BITS-1:0] pos_w;
	logic signed [CMP_BITS-1:0] tgt_w;
	logic                       run_eff;
	logic                       wrap;

	assign pos_w   = CMP_BITS'($signed(count_q));
	assign tgt_w   = CMP_BITS'($signed(target));
	assign run_eff = run_q | start;
	assign wrap    = (phase_q == PHASE_LAST);

	always_comb begin
		phase_n = phase_q;
		count_n = count_q;
		run_n   = run_eff;
		drive_n = drive_q;
		if (tgt_w == pos_w) begin
			run_n   = 1'b0;
			drive_n = off_pattern;
		end else if (run_eff) begin
			drive_n = phase_table[phase_q*COIL_BITS +: COIL_BITS];
			if (tgt_w < pos_w) begin
				// Moving down: the counter drops as the phase wraps past seven.
				if (wrap)
					count_n = count_q - POSITION_BITS'(1);
				phase_n = phase_q + PHASE_BITS'(1);
			end else begin
				if (wrap)
					count_n = count_q + POSITION_BITS'(1);
				phase_n = phase_q - PHASE_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			count_q <= '0;
			run_q   <= 1'b0;
			drive_q <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			count_q <= count_n;
			run_q   <= run_n;
			drive_q <= drive_n;
		end
	end

	assign res.drive    = drive_n;
	assign res.position = TARGET_BITS'(count_n);
	assign res.running  = run_n;

endmodule

`default_nettype wire

### rtl/dual_stepper_half_step_positioner_core.sv
// A result is registered and appears on the master side in the cycle after its input transaction.
// Throughput: one transaction per cycle; the next tick is taken while a result waits,
// as long as the result register is empty or being drained in the same cycle.
// Reset: arst_n clears the phases, counters, run flags, held coil patterns and the
// result valid flag, and loads the phase tables and off patterns with their defaults.
// ----------------------------------------------------------------------------
// Dual stepper half-step positioner core
// Two independent half-step stepper channels advanced by one timer tick per
// stream transaction, with an APB-style register port for the coil tables.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_stepper_half_step_positioner_core
	import dshsp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	// Tick stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [15:0] target_updown, [31:16] target_openclose, [32] start_updown,
	// [33] start_openclose, [36:34] alarm_in, [39:37] zero
	input  wire logic [39:0] s_axis_tdata,

	// Result stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [3:0] coils_updown, [7:4] coils_openclose, [23:8] position_updown,
	// [39:24] position_openclose, [40] running_updown, [41] running_openclose,
	// [42] both_stopped, [45:43] alarm_out, [47:46] zero
	output logic [47:0]      m_axis_tdata,

	// Register port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// ------------------------------------------------------------------
	// Configuration registers. Each register lies at byte address 4*i, so
	// the index is paddr[3:2]. Writes take effect on the access phase.
	// ------------------------------------------------------------------
	logic [31:0]          ud_table_q;
	logic [31:0]          oc_table_q;
	logic [COIL_BITS-1:0] ud_off_q;
	logic [COIL_BITS-1:0] oc_off_q;
	logic                 cfg_write;
	logic [1:0]           cfg_index;

	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;
	assign cfg_index = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ud_table_q <= TABLE_RESET;
			oc_table_q <= TABLE_RESET;
			ud_off_q   <= OFF_RESET;
			oc_off_q   <= OFF_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_UD_TABLE: ud_table_q <= pwdata;
				REG_OC_TABLE: oc_table_q <= pwdata;
				REG_UD_OFF:   ud_off_q   <= pwdata[COIL_BITS-1:0];
				REG_OC_OFF:   oc_off_q   <= pwdata[COIL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_index)
			REG_UD_TABLE: prdata = ud_table_q;
			REG_OC_TABLE: prdata = oc_table_q;
			REG_UD_OFF:   prdata = 32'(ud_off_q);
			REG_OC_OFF:   prdata = 32'(oc_off_q);
			default:      prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input side. The result register parts the two streams: a new tick is
	// accepted whenever that register is empty or is being emptied now.
	// ------------------------------------------------------------------
	logic                   accept;
	logic [TARGET_BITS-1:0] target_ud;
	logic [TARGET_BITS-1:0] target_oc;
	logic                   start_ud;
	logic                   start_oc;
	logic [ALARM_BITS-1:0]  alarm_in;

	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign accept        = s_axis_tvalid & s_axis_tready;

	assign target_ud = s_axis_tdata[15:0];
	assign target_oc = s_axis_tdata[31:16];
	assign start_ud  = s_axis_tdata[32];
	assign start_oc  = s_axis_tdata[33];
	assign alarm_in  = s_axis_tdata[36:34];

	// ------------------------------------------------------------------
	// The two channels hold their own state, which advances on every
	// accepted transaction, and report the values after this tick.
	// ------------------------------------------------------------------
	chan_res_t ud_res;
	chan_res_t oc_res;

	dshsp_channel u_updown (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.start       (start_ud),
		.target      (target_ud),
		.phase_table (ud_table_q),
		.off_pattern (ud_off_q),
		.res         (ud_res)
	);

	dshsp_channel u_openclose (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.start       (start_oc),
		.target      (target_oc),
		.phase_table (oc_table_q),
		.off_pattern (oc_off_q),
		.res         (oc_res)
	);

	// ------------------------------------------------------------------
	// Stopped flag and alarm remap. Only when neither motor runs are the
	// warning and clearing codes rewritten; everything else passes through.
	// ------------------------------------------------------------------
	logic                  stopped;
	logic [ALARM_BITS-1:0] alarm_res;

	assign stopped = !ud_res.running && !oc_res.running;

	always_comb begin
		alarm_res = alarm_in;
		if (stopped) begin
			if (alarm_in == ALARM_WARN_IN)
				alarm_res = ALARM_WARN_OUT;
			else if (alarm_in == ALARM_CLEAR_IN)
				alarm_res = ALARM_CLEAR_OUT;
		end
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	logic        out_valid_q;
	logic [47:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {2'b00, alarm_res, stopped, oc_res.running, ud_res.running,
				oc_res.position, ud_res.position, oc_res.drive, ud_res.drive};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

### rtl/dshsp_checker.sv
// ----------------------------------------------------------------------------
// Dual stepper half-step positioner checker
// Port-level checks on the result stream, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module dshsp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [47:0] m_axis_tdata
);

	// A stalled result keeps its valid and its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// The stopped flag is exactly the absence of both run flags.
	a_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[42] == (!m_axis_tdata[40] && !m_axis_tdata[41])))
		else $error("stopped flag disagrees with run flags");

	// With both motors stopped the warning and clearing codes never leave.
	a_alarm_remap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[42] |->
			(m_axis_tdata[45:43] != 3'd4) && (m_axis_tdata[45:43] != 3'd5))
		else $error("alarm code not remapped while stopped");

	// An empty result register never holds back the tick stream.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with no result pending");

endmodule

bind dual_stepper_half_step_positioner_core dshsp_checker u_dshsp_checker (.*);

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Dual stepper half-step positioner testbench
// Drives timer ticks into the core, predicts both channels from their phase,
// counter and run flag, and checks every result transaction field by field.
// The register port is exercised between phases at several table settings,
// extremes included, and each write is read back.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import dshsp_pkg::*;

	localparam int RANDOM_PER_PHASE = 240;
	localparam int WATCHDOG_LIMIT   = 1000;
	localparam int DRAIN_CYCLES     = 4;

	// One tick as it travels on the slave side.
	typedef struct packed {
		logic signed [TARGET_BITS-1:0] target_ud;
		logic signed [TARGET_BITS-1:0] target_oc;
		logic                          start_ud;
		logic                          start_oc;
		logic [ALARM_BITS-1:0]         alarm;
	} tick_t;

	// One status report as it travels on the master side.
	typedef struct packed {
		logic [COIL_BITS-1:0]   coils_ud;
		logic [COIL_BITS-1:0]   coils_oc;
		logic [TARGET_BITS-1:0] pos_ud;
		logic [TARGET_BITS-1:0] pos_oc;
		logic                   run_ud;
		logic                   run_oc;
		logic                   stopped;
		logic [ALARM_BITS-1:0]  alarm;
	} report_t;

	// Shadow of one motor channel.
	typedef struct packed {
		logic [PHASE_BITS-1:0]    phase;
		logic [POSITION_BITS-1:0] count;
		logic                     run;
		logic [COIL_BITS-1:0]     drive;
	} motor_t;

	typedef struct packed {
		tick_t   stim;
		logic    typed;
		report_t want;
	} dir_row_t;

	localparam int DIRECTED_ROWS = 24;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Register shadows.
	logic [31:0]          ud_table;
	logic [31:0]          oc_table;
	logic [COIL_BITS-1:0] ud_off;
	logic [COIL_BITS-1:0] oc_off;

	motor_t ud_motor;
	motor_t oc_motor;

	// Positions the random stimulus is currently steering each motor toward.
	logic signed [TARGET_BITS-1:0] goal_ud;
	logic signed [TARGET_BITS-1:0] goal_oc;

	report_t awaited_reports [$];

	int fails = 0;
	int ticks_sent = 0;
	int reports_checked = 0;
	int stopped_reports = 0;
	int settings_applied = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int stall_tick = 0;

	dir_row_t directed_rows [DIRECTED_ROWS] = '{
		// Stopped at the origin: warning code is remapped, clear code too, others pass.
		'{'{16'sd0, 16'sd0, 1'b0, 1'b0, ALARM_WARN_IN}, 1'b1,
			'{4'h0, 4'h0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b1, ALARM_WARN_OUT}},
		'{'{16'sd0, 16'sd0, 1'b0, 1'b0, ALARM_CLEAR_IN}, 1'b1,
			'{4'h0, 4'h0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b1, ALARM_CLEAR_OUT}},
		// A start at the target is cleared within the same tick.
		'{'{16'sd0, 16'sd0, 1'b1, 1'b1, 3'd7}, 1'b1,
			'{4'h0, 4'h0, 16'h0, 16'h0, 1'b0, 1'b0, 1'b1, 3'd7}},
		// First step upward drives phase 0 of the default table; alarm is not remapped.
		'{'{16'sd1, 16'sd0, 1'b1, 1'b0, ALARM_WARN_IN}, 1'b1,
			'{4'h1, 4'h0, 16'h0, 16'h0, 1'b1, 1'b0, 1'b0, ALARM_WARN_IN}},
		'{'{16'sd1, 16'sd0, 1'b0, 1'b0, ALARM_CLEAR_IN}, 1'b0, '0},
		'{'{16'sd1, 16'sd0, 1'b0, 1'b0, 3'd3}, 1'b0, '0},
		// Stopped away from the target: coils hold and nothing moves.
		'{'{-16'sd1, 16'sd0, 1'b0, 1'b0, 3'd6}, 1'b0, '0},
		'{'{-16'sd1, 16'sd0, 1'b0, 1'b0, ALARM_WARN_IN}, 1'b0, '0},
		// Both motors walk downward through a full phase cycle and beyond.
		'{'{-16'sd1, -16'sd1, 1'b1, 1'b1, 3'd1}, 1'b0, '0},
		'{'{-16'sd1, -16'sd1, 1'b0, 1'b0, 3'd2}, 1'b0, '0},
		'{'{-16'sd1, -16'sd1, 1'b0, 1'b0, 3'd0}, 1'b0, '0},
		'{'{-16'sd1, -16'sd1, 1'b0, 1'b0, ALARM_CLEAR_IN}, 1'b0, '0},
		'{'{-16'sd1, -16'sd1, 1'b0, 1'b0, ALARM_WARN_IN}, 1'b0, '0},
		'{'{-16'sd1, -16'sd1, 1'b0, 1'b0, 3'd6}, 1'b0, '0},
		'{'{-16'sd1, -16'sd1, 1'b0, 1'b0, 3'd7}, 1'b0, '0},
		'{'{-16'sd1, -16'sd1, 1'b0, 1'b0, 3'd3}, 1'b0, '0},
		'{'{-16'sd1, -16'sd1, 1'b0, 1'b0, 3'd1}, 1'b0, '0},
		'{'{-16'sd1, -16'sd1, 1'b0, 1'b0, ALARM_WARN_IN}, 1'b0, '0},
		// Targets at both ends of the signed range.
		'{'{16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 3'd2}, 1'b0, '0},
		'{'{16'sh8000, 16'sh7FFF, 1'b0, 1'b0, ALARM_CLEAR_IN}, 1'b0, '0},
		'{'{16'sh8000, 16'sh7FFF, 1'b1, 1'b0, 3'd7}, 1'b0, '0},
		'{'{16'sh7FFF, 16'sh8000, 1'b0, 1'b1, 3'd0}, 1'b0, '0},
		// Return to the origin and start over it.
		'{'{16'sd0, 16'sd0, 1'b1, 1'b1, ALARM_WARN_IN}, 1'b0, '0},
		'{'{16'sd0, 16'sd0, 1'b0, 1'b0, ALARM_CLEAR_IN}, 1'b0, '0}
	};

	dual_stepper_half_step_positioner_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// One channel for one tick. At the target the run flag drops and the off
	// pattern is driven; otherwise a running channel drives its current phase
	// and steps, moving the counter only when phase 7 is left.
	function automatic void advance_motor(inout motor_t m,
			input logic signed [TARGET_BITS-1:0] aim_pos, input logic [31:0] coil_table,
			input logic [COIL_BITS-1:0] off);
		longint here;
		longint aim;
		here = longint'($signed(m.count));
		aim  = longint'(aim_pos);
		if (aim == here) begin
			m.run   = 1'b0;
			m.drive = off;
			return;
		end
		if (!m.run)
			return;
		m.drive = coil_table[int'(m.phase)*COIL_BITS +: COIL_BITS];
		if (aim < here) begin
			if (m.phase == PHASE_LAST)
				m.count = m.count - 1'b1;
			m.phase = m.phase + 1'b1;
		end else begin
			if (m.phase == PHASE_LAST)
				m.count = m.count + 1'b1;
			m.phase = m.phase - 1'b1;
		end
	endfunction

	function automatic report_t step_motors(input tick_t t);
		report_t r;
		logic [ALARM_BITS-1:0] code;
		if (t.start_ud)
			ud_motor.run = 1'b1;
		if (t.start_oc)
			oc_motor.run = 1'b1;
		advance_motor(ud_motor, t.target_ud, ud_table, ud_off);
		advance_motor(oc_motor, t.target_oc, oc_table, oc_off);
		r.stopped = !ud_motor.run && !oc_motor.run;
		code = t.alarm;
		if (r.stopped) begin
			if (code == ALARM_WARN_IN)
				code = ALARM_WARN_OUT;
			else if (code == ALARM_CLEAR_IN)
				code = ALARM_CLEAR_OUT;
		end
		r.coils_ud = ud_motor.drive;
		r.coils_oc = oc_motor.drive;
		r.pos_ud   = TARGET_BITS'(ud_motor.count);
		r.pos_oc   = TARGET_BITS'(oc_motor.count);
		r.run_ud   = ud_motor.run;
		r.run_oc   = oc_motor.run;
		r.alarm    = code;
		return r;
	endfunction

	// Mostly keeps the goal; now and then moves it a few counts from where the
	// motor is, parks it on the motor, or throws it somewhere far away.
	function automatic logic signed [TARGET_BITS-1:0] steer_goal(
			input logic signed [TARGET_BITS-1:0] goal, input motor_t m);
		logic signed [TARGET_BITS-1:0] here;
		int pick;
		int offset;
		here = TARGET_BITS'(m.count);
		if ($urandom_range(0, 7) != 0)
			return goal;
		pick = $urandom_range(0, 15);
		if (pick < 2)
			return TARGET_BITS'($urandom);
		if (pick < 4)
			return here;
		offset = int'($urandom_range(0, 6)) - 3;
		return TARGET_BITS'(int'(here) + offset);
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		goal_ud = steer_goal(goal_ud, ud_motor);
		goal_oc = steer_goal(goal_oc, oc_motor);
		// An odd tick carries a stray target instead of the goal.
		t.target_ud = ($urandom_range(0, 15) == 0) ? TARGET_BITS'($urandom) : goal_ud;
		t.target_oc = ($urandom_range(0, 15) == 0) ? TARGET_BITS'($urandom) : goal_oc;
		t.start_ud  = ($urandom_range(0, 3) == 0);
		t.start_oc  = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 2) == 0)
			t.alarm = $urandom_range(0, 1) ? ALARM_WARN_IN : ALARM_CLEAR_IN;
		else
			t.alarm = ALARM_BITS'($urandom_range(0, 7));
		return t;
	endfunction

	// Offers one tick, waits for its transaction, then records what it should
	// produce. Ticks go out in bursts; a gap may follow each burst.
	task automatic send_tick(input tick_t t, input logic typed, input report_t want);
		report_t predicted;
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, t.alarm, t.start_oc, t.start_ud, t.target_oc, t.target_ud};
		do @(posedge clk); while (!s_axis_tready);
		predicted = step_motors(t);
		awaited_reports.push_back(typed ? want : predicted);
		ticks_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stops offering ticks and waits until every report has come back.
	task automatic drain_reports();
		s_axis_tvalid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] shadow_value(input logic [1:0] idx);
		case (idx)
			REG_UD_TABLE: return ud_table;
			REG_OC_TABLE: return oc_table;
			REG_UD_OFF:   return 32'(ud_off);
			default:      return 32'(oc_off);
		endcase
	endfunction

	// One register transfer: setup cycle, then access cycle until pready.
	// A write updates the shadow; a read is compared with it.
	task automatic reg_access(input logic [1:0] idx, input logic is_write,
			input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (is_write) begin
			case (idx)
				REG_UD_TABLE: ud_table = value;
				REG_OC_TABLE: oc_table = value;
				REG_UD_OFF:   ud_off   = value[COIL_BITS-1:0];
				default:      oc_off   = value[COIL_BITS-1:0];
			endcase
		end else if (prdata !== shadow_value(idx)) begin
			$error("register %0d: expected %0h, got %0h", idx, shadow_value(idx), prdata);
			fails++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_and_check(input logic [1:0] idx, input logic [31:0] value);
		reg_access(idx, 1'b1, value);
		reg_access(idx, 1'b0, '0);
	endtask

	task automatic apply_setting(input logic [31:0] ud_tab, input logic [31:0] oc_tab,
			input logic [31:0] ud_idle, input logic [31:0] oc_idle);
		write_and_check(REG_UD_TABLE, ud_tab);
		write_and_check(REG_OC_TABLE, oc_tab);
		write_and_check(REG_UD_OFF, ud_idle);
		write_and_check(REG_OC_OFF, oc_idle);
		settings_applied++;
	endtask

	task automatic random_phase();
		repeat (RANDOM_PER_PHASE)
			send_tick(random_tick(), 1'b0, '0);
	endtask

	// Receiver: stall patterns, set by the stall counter, that step in turn between always
	// ready, half ready at random, ready at counter multiples of four, and mostly ready.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		case ((stall_tick / 128) % 4)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= $urandom_range(0, 1);
			2:       m_axis_tready <= (stall_tick % 4 == 0);
			default: m_axis_tready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	// Every result transaction is compared with the oldest awaited report.
	always @(posedge clk) begin
		report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_reports.size() == 0) begin
				$error("result transaction with no tick awaiting it: %0h", m_axis_tdata);
				fails++;
			end else begin
				want = awaited_reports.pop_front();
				check_field("coils_updown", want.coils_ud, m_axis_tdata[3:0]);
				check_field("coils_openclose", want.coils_oc, m_axis_tdata[7:4]);
				check_field("position_updown", want.pos_ud, m_axis_tdata[23:8]);
				check_field("position_openclose", want.pos_oc, m_axis_tdata[39:24]);
				check_field("running_updown", want.run_ud, m_axis_tdata[40]);
				check_field("running_openclose", want.run_oc, m_axis_tdata[41]);
				check_field("both_stopped", want.stopped, m_axis_tdata[42]);
				check_field("alarm_out", want.alarm, m_axis_tdata[45:43]);
				reports_checked++;
				if (want.stopped)
					stopped_reports++;
			end
		end
	end

	// Watchdog: too many cycles without any transaction on either stream or
	// the register port means the core has hung.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		m_axis_tready <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		ud_table = TABLE_RESET;
		oc_table = TABLE_RESET;
		ud_off   = OFF_RESET;
		oc_off   = OFF_RESET;
		ud_motor = '0;
		oc_motor = '0;
		goal_ud  = '0;
		goal_oc  = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values of the registers.
		reg_access(REG_UD_TABLE, 1'b0, '0);
		reg_access(REG_OC_TABLE, 1'b0, '0);
		reg_access(REG_UD_OFF, 1'b0, '0);
		reg_access(REG_OC_OFF, 1'b0, '0);

		foreach (directed_rows[i])
			send_tick(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
		random_phase();
		drain_reports();

		// Extreme tables, distinct nibbles, a random setting, then back to defaults.
		apply_setting(32'h0000_0000, 32'hFFFF_FFFF, 32'(4'hF), 32'(4'h0));
		random_phase();
		drain_reports();
		apply_setting(32'hFFFF_FFFF, 32'h0000_0000, 32'(4'h0), 32'(4'hF));
		random_phase();
		drain_reports();
		apply_setting(32'h1234_5678, 32'h8765_4321, 32'(4'h5), 32'(4'hA));
		random_phase();
		drain_reports();
		apply_setting($urandom, $urandom, $urandom_range(0, 15), $urandom_range(0, 15));
		random_phase();
		drain_reports();
		apply_setting(TABLE_RESET, TABLE_RESET, 32'(OFF_RESET), 32'(OFF_RESET));
		random_phase();
		drain_reports();

		$display("Sent %0d ticks across %0d register settings besides reset.",
			ticks_sent, settings_applied);
		$display("Checked %0d status reports, %0d of them with both motors stopped.",
			reports_checked, stopped_reports);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
